>>> rtl/core/trpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the tank refill pump controller.
// No dependencies; compiled first.
package trpc_pkg;

    // Field widths fixed by the item layout
    localparam int RUNTIME_W  = 20;
    localparam int INTERVAL_W = 27;
    localparam int SETTLE_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // Register reset values
    localparam logic [RUNTIME_W-1:0]  RUNTIME_RESET  = 20'd600000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 27'd300000;
    localparam logic [3:0]            HW_ALL         = 4'hF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CIRC_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RUNTIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PREF_ROUTE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_SUMP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HW_PRESENT = 3'd6;

    // Request codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_MANUAL = 2'd2;

    // Preferred route codes
    localparam logic [1:0] PREF_AUTO = 2'd0;
    localparam logic [1:0] PREF_FISH = 2'd1;
    localparam logic [1:0] PREF_SUMP = 2'd2;

    // Active route codes
    localparam logic [1:0] ROUTE_FISH = 2'd1;
    localparam logic [1:0] ROUTE_SUMP = 2'd2;
    localparam logic [1:0] ROUTE_NONE = 2'd3;

    // Reported state codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MIX     = 3'd1;
    localparam logic [2:0] ST_WAIT    = 3'd2;
    localparam logic [2:0] ST_SETTLE  = 3'd3;
    localparam logic [2:0] ST_FISH    = 3'd4;
    localparam logic [2:0] ST_BLOCKED = 3'd5;
    localparam logic [2:0] ST_ALARM   = 3'd6;

    typedef struct packed {
        logic                  circulation_on;
        logic                  fish_pump_on;
        logic                  sump_valve_on;
        logic [1:0]            active_route;
        logic [2:0]            state_code;
        logic                  alarm_active;
        logic                  route_blocked;
        logic                  settling_active;
        logic [SETTLE_W-1:0]   settle_remaining_ms;
        logic [INTERVAL_W-1:0] interval_remaining_ms;
        logic                  overflow_flag;
    } rsp_t;

endpackage

>>> rtl/core/trpc_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one input item.
// No dependencies.
interface trpc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        level_low;
    logic        level_high;
    logic        overflow_sensed;
    logic        manual_on;

    modport source (output valid, req_type, now_ms, level_low, level_high,
                    overflow_sensed, manual_on, input ready);
    modport sink   (input valid, req_type, now_ms, level_low, level_high,
                    overflow_sensed, manual_on, output ready);
endinterface

>>> rtl/core/trpc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result item.
// No dependencies.
interface trpc_rsp_if;
    logic        valid;
    logic        ready;
    logic        circulation_on;
    logic        fish_pump_on;
    logic        sump_valve_on;
    logic [1:0]  active_route;
    logic [2:0]  state_code;
    logic        alarm_active;
    logic        route_blocked;
    logic        settling_active;
    logic [16:0] settle_remaining_ms;
    logic [26:0] interval_remaining_ms;
    logic        overflow_flag;

    modport source (output valid, circulation_on, fish_pump_on, sump_valve_on,
                    active_route, state_code, alarm_active, route_blocked,
                    settling_active, settle_remaining_ms, interval_remaining_ms,
                    overflow_flag, input ready);
    modport sink   (input valid, circulation_on, fish_pump_on, sump_valve_on,
                    active_route, state_code, alarm_active, route_blocked,
                    settling_active, settle_remaining_ms, interval_remaining_ms,
                    overflow_flag, output ready);
endinterface

>>> rtl/core/tank_refill_pump_controller.sv
`timescale 1ns / 1ps
// Tank refill pump controller top level: config registers, control state,
// one-pass tick logic and a two-deep result buffer. Uses trpc_pkg, trpc_req_if, trpc_rsp_if.
// An item's result is registered in the output register, or in the skid entry if that waits.
// Throughput: one item per cycle while the skid entry is empty; the single-pass update
// of the control state and the output/skid register pair set that figure.
// Reset (rst_n low, asynchronous): registers at their reset values, alarm and
// timestamps cleared, held result all off with route none, buffer empty.
module tank_refill_pump_controller
    import trpc_pkg::*;
#(
    parameter int unsigned SETTLE_TIME_MS        = 120000,
    parameter int unsigned MAX_RUNTIME_LIMIT_MS  = 600000,
    parameter int unsigned MAX_INTERVAL_LIMIT_MS = 86400000
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    trpc_req_if.sink              req,
    trpc_rsp_if.source            rsp
);

    // Runtime register must hold the clamp limit as well as any 20-bit value
    localparam int RUN_LIM_W = $clog2(MAX_RUNTIME_LIMIT_MS + 1);
    localparam int RUN_W     = (RUN_LIM_W > RUNTIME_W) ? RUN_LIM_W : RUNTIME_W;

    localparam logic [31:0] SETTLE_C  = 32'(SETTLE_TIME_MS);
    localparam logic [31:0] RUN_LIM_C = 32'(MAX_RUNTIME_LIMIT_MS);
    localparam logic [31:0] INT_LIM_C = 32'(MAX_INTERVAL_LIMIT_MS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                  circ_en_reg;
    logic                  auto_en_reg;
    logic [RUN_W-1:0]      runtime_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [1:0]            pref_route_reg;
    logic                  allow_sump_reg;
    logic [3:0]            hw_reg;

    logic [RUNTIME_W-1:0]  cfg_runtime;
    logic [INTERVAL_W-1:0] cfg_interval;

    // Clamp on write: zero or too long a runtime becomes the limit
    always_comb
    begin
        cfg_runtime  = cfg_wdata[RUNTIME_W-1:0];
        cfg_interval = cfg_wdata[INTERVAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_en_reg    <= 1'b1;
            auto_en_reg    <= 1'b1;
            runtime_reg    <= RUN_W'(RUNTIME_RESET);
            interval_reg   <= INTERVAL_RESET;
            pref_route_reg <= PREF_AUTO;
            allow_sump_reg <= 1'b0;
            hw_reg         <= HW_ALL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CIRC_EN:    circ_en_reg <= cfg_wdata[0];
                REG_AUTO_EN:    auto_en_reg <= cfg_wdata[0];
                REG_RUNTIME:
                begin
                    if (cfg_runtime == '0 || 32'(cfg_runtime) > RUN_LIM_C)
                        runtime_reg <= RUN_LIM_C[RUN_W-1:0];
                    else
                        runtime_reg <= RUN_W'(cfg_runtime);
                end
                REG_INTERVAL:
                begin
                    // The limit only bites when it is below the 27-bit range
                    if (32'(cfg_interval) > INT_LIM_C)
                        interval_reg <= INT_LIM_C[INTERVAL_W-1:0];
                    else
                        interval_reg <= cfg_interval;
                end
                REG_PREF_ROUTE: pref_route_reg <= cfg_wdata[1:0];
                REG_ALLOW_SUMP: allow_sump_reg <= cfg_wdata[0];
                REG_HW_PRESENT: hw_reg <= cfg_wdata[3:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state; a timestamp of zero means "not started" / "never"
    // ------------------------------------------------------------------
    logic        alarm_reg,      alarm_next;
    logic [31:0] start_reg,      start_next;
    logic [31:0] stop_reg,       stop_next;
    logic [31:0] dilution_reg,   dilution_next;
    logic        was_on_reg,     was_on_next;
    logic        manual_reg,     manual_next;
    rsp_t        held_reg,       held_next;

    // Result buffer: output register plus one skid entry
    rsp_t        out_reg;
    logic        out_valid_reg;
    rsp_t        skid_reg;
    logic        skid_valid_reg;

    logic        in_xfer;
    logic        out_xfer;

    assign req.ready = !skid_valid_reg;
    assign in_xfer   = req.valid && !skid_valid_reg;
    assign out_xfer  = out_valid_reg && rsp.ready;

    // ------------------------------------------------------------------
    // Tick logic
    // ------------------------------------------------------------------
    logic        has_circ, has_refill, has_level;
    logic        low, high;
    logic        circ, refill, blocked, waiting, rblk, settling;
    logic        circ_out, refill_out;
    logic [1:0]  route, active, picked;
    logic [31:0] stop_elapsed, run_elapsed, settle_elapsed, settle_diff;
    logic [INTERVAL_W-1:0] left;

    // Route resolution from preference and fitted hardware
    always_comb
    begin
        case (pref_route_reg)
            PREF_FISH: picked = hw_reg[1] ? ROUTE_FISH : ROUTE_NONE;
            PREF_SUMP: picked = hw_reg[2] ? ROUTE_SUMP : ROUTE_NONE;
            PREF_AUTO:
            begin
                if (allow_sump_reg && hw_reg[2])
                    picked = ROUTE_SUMP;
                else if (hw_reg[1])
                    picked = ROUTE_FISH;
                else if (hw_reg[2])
                    picked = ROUTE_SUMP;
                else
                    picked = ROUTE_NONE;
            end
            default:   picked = ROUTE_NONE;
        endcase
    end

    // Lockout left since the last refill stop
    always_comb
    begin
        stop_elapsed = req.now_ms - stop_reg;
        if (stop_reg == '0 || interval_reg == '0)
            left = '0;
        else if (stop_elapsed >= 32'(interval_reg))
            left = '0;
        else
            left = interval_reg - stop_elapsed[INTERVAL_W-1:0];
    end

    always_comb
    begin
        has_circ   = hw_reg[0];
        has_refill = hw_reg[1] | hw_reg[2];
        has_level  = hw_reg[3];
        low        = has_level & req.level_low;
        high       = has_level & req.level_high;

        alarm_next    = alarm_reg;
        start_next    = start_reg;
        stop_next     = stop_reg;
        dilution_next = dilution_reg;
        was_on_next   = was_on_reg;
        manual_next   = manual_reg;
        held_next     = held_reg;

        circ           = circ_en_reg;
        refill         = 1'b0;
        blocked        = 1'b0;
        waiting        = 1'b0;
        rblk           = 1'b0;
        settling       = 1'b0;
        route          = ROUTE_NONE;
        circ_out       = 1'b0;
        refill_out     = 1'b0;
        active         = ROUTE_NONE;
        run_elapsed    = '0;
        settle_elapsed = '0;
        settle_diff    = '0;

        case (req.req_type)
            REQ_CLEAR:
            begin
                // Drop the alarm and forget the running refill and dilution
                alarm_next              = 1'b0;
                start_next              = '0;
                was_on_next             = 1'b0;
                dilution_next           = '0;
                held_next.active_route  = ROUTE_NONE;
                held_next.state_code    = ST_IDLE;
                held_next.alarm_active  = 1'b0;
                held_next.route_blocked = 1'b0;
            end
            REQ_MANUAL:
            begin
                manual_next = req.manual_on;
                if (!req.manual_on)
                    start_next = '0;
            end
            REQ_TICK:
            begin
                if (low && high)
                    alarm_next = 1'b1;

                // Decide whether a refill is wanted
                if (manual_reg)
                begin
                    if (!has_refill)
                        blocked = 1'b1;
                    else
                        refill = 1'b1;
                end
                else if (auto_en_reg)
                begin
                    if (!has_refill || !has_level)
                        blocked = 1'b1;
                    else if (high)
                        start_next = '0;
                    else if (low)
                    begin
                        if (left != '0 && stop_reg != '0)
                            waiting = 1'b1;
                        else
                            refill = 1'b1;
                    end
                    else
                        start_next = '0;
                end
                else
                    start_next = '0;

                // Resolve the route and enforce the runtime limit
                if (refill)
                begin
                    if (start_next == '0)
                        start_next = req.now_ms;
                    route = picked;
                    if (picked == ROUTE_NONE)
                    begin
                        refill  = 1'b0;
                        blocked = 1'b1;
                        rblk    = 1'b1;
                    end
                    run_elapsed = req.now_ms - start_next;
                    if (refill && run_elapsed >= 32'(runtime_reg))
                    begin
                        refill      = 1'b0;
                        manual_next = 1'b0;
                        alarm_next  = 1'b1;
                    end
                end

                if (alarm_next)
                begin
                    circ   = 1'b0;
                    refill = 1'b0;
                    route  = ROUTE_NONE;
                end

                circ_out   = circ & has_circ;
                refill_out = refill & has_refill;
                active     = refill_out ? route : ROUTE_NONE;
                if (refill_out && (active == ROUTE_FISH || active == ROUTE_SUMP))
                    dilution_next = req.now_ms;

                // Settling hold after water went into the mix tank
                settle_elapsed = req.now_ms - dilution_next;
                settle_diff    = SETTLE_C - settle_elapsed;
                if (dilution_next != '0 && settle_elapsed < SETTLE_C)
                    settling = !refill_out;
                else
                    settle_diff = '0;

                // Falling edge of the refill drive starts the lockout
                if (was_on_reg && !refill_out)
                begin
                    stop_next  = req.now_ms;
                    start_next = '0;
                end
                was_on_next = refill_out;

                held_next.circulation_on        = circ_out;
                held_next.fish_pump_on          = refill_out && active == ROUTE_FISH;
                held_next.sump_valve_on         = refill_out && active == ROUTE_SUMP;
                held_next.active_route          = active;
                held_next.alarm_active          = alarm_next;
                held_next.route_blocked         = rblk;
                held_next.settling_active       = settling;
                held_next.settle_remaining_ms   = settle_diff[SETTLE_W-1:0];
                held_next.interval_remaining_ms = left;
                held_next.overflow_flag         = req.overflow_sensed;

                if (alarm_next)
                    held_next.state_code = ST_ALARM;
                else if (blocked)
                    held_next.state_code = ST_BLOCKED;
                else if (waiting)
                    held_next.state_code = ST_WAIT;
                else if (refill_out)
                    held_next.state_code = (active == ROUTE_FISH) ? ST_FISH : ST_MIX;
                else if (settling)
                    held_next.state_code = ST_SETTLE;
                else
                    held_next.state_code = ST_IDLE;
            end
            default: ;  // unknown request: hold everything
        endcase
    end

    // Advance the control state on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg    <= 1'b0;
            start_reg    <= '0;
            stop_reg     <= '0;
            dilution_reg <= '0;
            was_on_reg   <= 1'b0;
            manual_reg   <= 1'b0;
            held_reg     <= '{active_route: ROUTE_NONE, state_code: ST_IDLE, default: '0};
        end
        else if (in_xfer)
        begin
            alarm_reg    <= alarm_next;
            start_reg    <= start_next;
            stop_reg     <= stop_next;
            dilution_reg <= dilution_next;
            was_on_reg   <= was_on_next;
            manual_reg   <= manual_next;
            held_reg     <= held_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: the skid entry catches a result while the output
    // register still waits; input stalls only while the skid is full
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xfer)
                skid_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg || out_xfer)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_xfer)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
                out_reg <= skid_reg;
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg || out_xfer)
                out_reg <= held_next;
            else
                skid_reg <= held_next;
        end
    end

    assign rsp.valid                 = out_valid_reg;
    assign rsp.circulation_on        = out_reg.circulation_on;
    assign rsp.fish_pump_on          = out_reg.fish_pump_on;
    assign rsp.sump_valve_on         = out_reg.sump_valve_on;
    assign rsp.active_route          = out_reg.active_route;
    assign rsp.state_code            = out_reg.state_code;
    assign rsp.alarm_active          = out_reg.alarm_active;
    assign rsp.route_blocked         = out_reg.route_blocked;
    assign rsp.settling_active       = out_reg.settling_active;
    assign rsp.settle_remaining_ms   = out_reg.settle_remaining_ms;
    assign rsp.interval_remaining_ms = out_reg.interval_remaining_ms;
    assign rsp.overflow_flag         = out_reg.overflow_flag;

endmodule

>>> tb/tank_refill_pump_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tank refill pump controller: a queue-fed driver,
// a checking monitor and a cycle-free predictor of the controller's result.
// Depends on trpc_pkg, trpc_req_if, trpc_rsp_if and tank_refill_pump_controller.
module tank_refill_pump_controller_tb;
    import trpc_pkg::*;

    // Timing and run-length constants
    localparam int TIMEOUT_NS     = 5_000_000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int NUM_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int HOLD_PHASE     = 6;
    localparam int MAX_PRINTED    = 100;

    // Controller constants at the instance's default parameters
    localparam int unsigned SETTLE_HOLD_MS    = 120000;
    localparam int unsigned RUNTIME_CLAMP_MS  = 600000;
    localparam int unsigned INTERVAL_CLAMP_MS = 86400000;

    // Codes that the package leaves out
    localparam logic [1:0]           REQ_RESERVED = 2'd3;
    localparam logic [1:0]           PREF_NONE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic        level_low;
        logic        level_high;
        logic        overflow_sensed;
        logic        manual_on;
    } tank_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    trpc_req_if req_ch();
    trpc_rsp_if rsp_ch();

    tank_refill_pump_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Mirror of the register file, after clamping
    logic                  cfg_circ_en;
    logic                  cfg_auto_en;
    logic [RUNTIME_W-1:0]  cfg_runtime;
    logic [INTERVAL_W-1:0] cfg_interval;
    logic [1:0]            cfg_pref_route;
    logic                  cfg_allow_sump;
    logic [3:0]            cfg_hw;

    // Mirror of the control state
    logic        alarm_q;
    logic        refill_was_on_q;
    logic        manual_q;
    logic [31:0] refill_start_q;
    logic [31:0] last_stop_q;
    logic [31:0] last_dilution_q;
    rsp_t        held_rsp;

    // Traffic bookkeeping
    tank_req_t   req_pending_q[$];
    rsp_t        predicted_rsp_q[$];
    tank_req_t   tx_item;
    rsp_t        rx_got;
    int          tx_wait;
    int          rx_wait;
    int unsigned req_issued_count;
    int unsigned rsp_seen_count;
    int unsigned mismatch_count;
    bit          no_gaps      = 1'b0;
    bit          hold_request = 1'b0;
    logic        rx_hold;
    logic [31:0] sim_now;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: the slowest correct run ends far sooner than this
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Print one line per mismatch (up to a cap) and count every one
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Draw the idle cycles one side spends before its next transfer
    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic tank_req_t mk_req(logic [1:0] kind, logic [31:0] stamp,
                                         logic lo, logic hi, logic ovf, logic man);
        tank_req_t r;
        r.req_type        = kind;
        r.now_ms          = stamp;
        r.level_low       = lo;
        r.level_high      = hi;
        r.overflow_sensed = ovf;
        r.manual_on       = man;
        return r;
    endfunction

    task automatic queue_req(input tank_req_t r);
        req_pending_q.push_back(r);
        req_issued_count++;
    endtask

    // Compute the result of one accepted item and advance the mirrored state.
    // Manual/reserved codes return the held result; a clear resets its status first.
    function automatic rsp_t predict_controller_rsp(input tank_req_t r);
        logic        has_circ;
        logic        has_refill;
        logic        has_level;
        logic        lvl_low;
        logic        lvl_high;
        logic        circ;
        logic        refill;
        logic        blocked;
        logic        waiting;
        logic        no_route;
        logic        circ_out;
        logic        refill_out;
        logic        settling;
        logic [1:0]  route;
        logic [1:0]  active;
        logic [31:0] lockout;
        logic [31:0] elapsed;
        logic [31:0] settle_left;

        if (r.req_type == REQ_CLEAR) begin
            alarm_q                = 1'b0;
            refill_start_q         = '0;
            refill_was_on_q        = 1'b0;
            last_dilution_q        = '0;
            held_rsp.active_route  = ROUTE_NONE;
            held_rsp.state_code    = ST_IDLE;
            held_rsp.alarm_active  = 1'b0;
            held_rsp.route_blocked = 1'b0;
            return held_rsp;
        end
        if (r.req_type == REQ_MANUAL) begin
            manual_q = r.manual_on;
            if (!manual_q)
                refill_start_q = '0;
            return held_rsp;
        end
        if (r.req_type != REQ_TICK)
            return held_rsp;

        has_circ   = cfg_hw[0];
        has_refill = cfg_hw[1] | cfg_hw[2];
        has_level  = cfg_hw[3];
        lvl_low    = has_level & r.level_low;
        lvl_high   = has_level & r.level_high;

        // Lockout left since the last refill stop; a zero stamp means never
        lockout = '0;
        if (last_stop_q != 0 && cfg_interval != 0) begin
            elapsed = r.now_ms - last_stop_q;
            if (elapsed < 32'(cfg_interval))
                lockout = 32'(cfg_interval) - elapsed;
        end

        if (lvl_low && lvl_high)
            alarm_q = 1'b1;
        circ     = cfg_circ_en;
        refill   = 1'b0;
        blocked  = 1'b0;
        waiting  = 1'b0;
        no_route = 1'b0;
        route    = ROUTE_NONE;

        if (manual_q) begin
            if (!has_refill)
                blocked = 1'b1;
            else
                refill = 1'b1;
        end else if (cfg_auto_en) begin
            if (!has_refill || !has_level)
                blocked = 1'b1;
            else if (lvl_high)
                refill_start_q = '0;
            else if (lvl_low) begin
                if (lockout != 0 && last_stop_q != 0)
                    waiting = 1'b1;
                else
                    refill = 1'b1;
            end else
                refill_start_q = '0;
        end else begin
            refill_start_q = '0;
        end

        if (refill) begin
            if (refill_start_q == 0)
                refill_start_q = r.now_ms;
            case (cfg_pref_route)
                PREF_FISH: route = cfg_hw[1] ? ROUTE_FISH : ROUTE_NONE;
                PREF_SUMP: route = cfg_hw[2] ? ROUTE_SUMP : ROUTE_NONE;
                PREF_AUTO: begin
                    if (cfg_allow_sump && cfg_hw[2])
                        route = ROUTE_SUMP;
                    else if (cfg_hw[1])
                        route = ROUTE_FISH;
                    else if (cfg_hw[2])
                        route = ROUTE_SUMP;
                    else
                        route = ROUTE_NONE;
                end
                default: route = ROUTE_NONE;
            endcase
            if (route == ROUTE_NONE) begin
                refill   = 1'b0;
                blocked  = 1'b1;
                no_route = 1'b1;
            end
            elapsed = r.now_ms - refill_start_q;
            if (refill && elapsed >= 32'(cfg_runtime)) begin
                refill   = 1'b0;
                manual_q = 1'b0;
                alarm_q  = 1'b1;
            end
        end
        if (alarm_q) begin
            circ   = 1'b0;
            refill = 1'b0;
            route  = ROUTE_NONE;
        end

        circ_out   = circ & has_circ;
        refill_out = refill & has_refill;
        active     = refill_out ? route : ROUTE_NONE;
        if (refill_out && (active == ROUTE_FISH || active == ROUTE_SUMP))
            last_dilution_q = r.now_ms;

        settling    = 1'b0;
        settle_left = '0;
        if (last_dilution_q != 0) begin
            elapsed = r.now_ms - last_dilution_q;
            if (elapsed < SETTLE_HOLD_MS) begin
                settling    = !refill_out;
                settle_left = SETTLE_HOLD_MS - elapsed;
            end
        end

        if (refill_was_on_q && !refill_out) begin
            last_stop_q    = r.now_ms;
            refill_start_q = '0;
        end
        refill_was_on_q = refill_out;

        if (alarm_q)
            held_rsp.state_code = ST_ALARM;
        else if (blocked)
            held_rsp.state_code = ST_BLOCKED;
        else if (waiting)
            held_rsp.state_code = ST_WAIT;
        else if (refill_out)
            held_rsp.state_code = (active == ROUTE_FISH) ? ST_FISH : ST_MIX;
        else if (settling)
            held_rsp.state_code = ST_SETTLE;
        else
            held_rsp.state_code = ST_IDLE;

        held_rsp.circulation_on        = circ_out;
        held_rsp.fish_pump_on          = refill_out && active == ROUTE_FISH;
        held_rsp.sump_valve_on         = refill_out && active == ROUTE_SUMP;
        held_rsp.active_route          = active;
        held_rsp.alarm_active          = alarm_q;
        held_rsp.route_blocked         = no_route;
        held_rsp.settling_active       = settling;
        held_rsp.settle_remaining_ms   = settle_left[SETTLE_W-1:0];
        held_rsp.interval_remaining_ms = lockout[INTERVAL_W-1:0];
        held_rsp.overflow_flag         = r.overflow_sensed;
        return held_rsp;
    endfunction

    // Compare one result with its prediction, field by field
    task automatic check_result(input rsp_t got, input rsp_t exp);
        if (got.circulation_on !== exp.circulation_on)
            report_mismatch($sformatf("result %0d circulation_on got %b exp %b",
                rsp_seen_count, got.circulation_on, exp.circulation_on));
        if (got.fish_pump_on !== exp.fish_pump_on)
            report_mismatch($sformatf("result %0d fish_pump_on got %b exp %b",
                rsp_seen_count, got.fish_pump_on, exp.fish_pump_on));
        if (got.sump_valve_on !== exp.sump_valve_on)
            report_mismatch($sformatf("result %0d sump_valve_on got %b exp %b",
                rsp_seen_count, got.sump_valve_on, exp.sump_valve_on));
        if (got.active_route !== exp.active_route)
            report_mismatch($sformatf("result %0d active_route got %0d exp %0d",
                rsp_seen_count, got.active_route, exp.active_route));
        if (got.state_code !== exp.state_code)
            report_mismatch($sformatf("result %0d state_code got %0d exp %0d",
                rsp_seen_count, got.state_code, exp.state_code));
        if (got.alarm_active !== exp.alarm_active)
            report_mismatch($sformatf("result %0d alarm_active got %b exp %b",
                rsp_seen_count, got.alarm_active, exp.alarm_active));
        if (got.route_blocked !== exp.route_blocked)
            report_mismatch($sformatf("result %0d route_blocked got %b exp %b",
                rsp_seen_count, got.route_blocked, exp.route_blocked));
        if (got.settling_active !== exp.settling_active)
            report_mismatch($sformatf("result %0d settling_active got %b exp %b",
                rsp_seen_count, got.settling_active, exp.settling_active));
        if (got.settle_remaining_ms !== exp.settle_remaining_ms)
            report_mismatch($sformatf("result %0d settle_remaining_ms got %0d exp %0d",
                rsp_seen_count, got.settle_remaining_ms, exp.settle_remaining_ms));
        if (got.interval_remaining_ms !== exp.interval_remaining_ms)
            report_mismatch($sformatf("result %0d interval_remaining_ms got %0d exp %0d",
                rsp_seen_count, got.interval_remaining_ms, exp.interval_remaining_ms));
        if (got.overflow_flag !== exp.overflow_flag)
            report_mismatch($sformatf("result %0d overflow_flag got %b exp %b",
                rsp_seen_count, got.overflow_flag, exp.overflow_flag));
    endtask

    // Driver: hold an offered item until its transfer, then idle for a drawn
    // number of cycles and offer the next pending one. Predict at the transfer.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predicted_rsp_q.push_back(predict_controller_rsp(tx_item));
                tx_wait = draw_wait();
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    req_ch.valid <= 1'b0;
                end else if (req_pending_q.size() != 0) begin
                    tx_item = req_pending_q.pop_front();
                    req_ch.req_type        <= tx_item.req_type;
                    req_ch.now_ms          <= tx_item.now_ms;
                    req_ch.level_low       <= tx_item.level_low;
                    req_ch.level_high      <= tx_item.level_high;
                    req_ch.overflow_sensed <= tx_item.overflow_sensed;
                    req_ch.manual_on       <= tx_item.manual_on;
                    req_ch.valid           <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction, then
    // drop ready for a drawn number of cycles, or for as long as the hold runs.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                rx_got = {rsp_ch.circulation_on, rsp_ch.fish_pump_on, rsp_ch.sump_valve_on,
                          rsp_ch.active_route, rsp_ch.state_code, rsp_ch.alarm_active,
                          rsp_ch.route_blocked, rsp_ch.settling_active,
                          rsp_ch.settle_remaining_ms, rsp_ch.interval_remaining_ms,
                          rsp_ch.overflow_flag};
                if (predicted_rsp_q.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing predicted",
                        rsp_seen_count));
                else
                    check_result(rx_got, predicted_rsp_q.pop_front());
                rsp_seen_count++;
                rx_wait = draw_wait();
            end
            if (rx_hold) begin
                rsp_ch.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering and the
    // controller's result buffer fills and back-pressures its input
    initial begin
        rx_hold = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rx_hold <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        end
    end

    // Write one register at a clock edge and track its clamped value
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        logic [31:0] v;
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CIRC_EN:    cfg_circ_en    = data[0];
            REG_AUTO_EN:    cfg_auto_en    = data[0];
            REG_RUNTIME: begin
                v = 32'(data[RUNTIME_W-1:0]);
                if (v == 0 || v > RUNTIME_CLAMP_MS)
                    v = RUNTIME_CLAMP_MS;
                cfg_runtime = v[RUNTIME_W-1:0];
            end
            REG_INTERVAL: begin
                v = 32'(data);
                if (v > INTERVAL_CLAMP_MS)
                    v = INTERVAL_CLAMP_MS;
                cfg_interval = v[INTERVAL_W-1:0];
            end
            REG_PREF_ROUTE: cfg_pref_route = data[1:0];
            REG_ALLOW_SUMP: cfg_allow_sump = data[0];
            REG_HW_PRESENT: cfg_hw         = data[3:0];
            default: ;
        endcase
    endtask

    // Program all registers: extremes in the first phases, random afterwards
    // (random values may carry junk above a register's width)
    task automatic program_regs(input int variant);
        logic [CFG_DATA_W-1:0] circ_d;
        logic [CFG_DATA_W-1:0] auto_d;
        logic [CFG_DATA_W-1:0] rt_d;
        logic [CFG_DATA_W-1:0] iv_d;
        logic [CFG_DATA_W-1:0] pref_d;
        logic [CFG_DATA_W-1:0] allow_d;
        logic [CFG_DATA_W-1:0] hw_d;
        case (variant)
            0: begin
                circ_d = CFG_DATA_W'(1); auto_d = CFG_DATA_W'(1); rt_d = '0; iv_d = '0;
                pref_d = CFG_DATA_W'(PREF_AUTO); allow_d = CFG_DATA_W'(1);
                hw_d = CFG_DATA_W'(HW_ALL);
            end
            1: begin
                circ_d = '0; auto_d = CFG_DATA_W'(1);
                rt_d = CFG_DATA_W'(1); iv_d = CFG_DATA_W'(1);
                pref_d = CFG_DATA_W'(PREF_FISH); allow_d = '0;
                hw_d = CFG_DATA_W'(4'b1010);
            end
            2: begin
                circ_d = CFG_DATA_W'(1); auto_d = CFG_DATA_W'(1);
                rt_d = CFG_DATA_W'(20'hFFFFF); iv_d = CFG_DATA_W'(27'h7FFFFFF);
                pref_d = CFG_DATA_W'(PREF_SUMP); allow_d = CFG_DATA_W'(1);
                hw_d = CFG_DATA_W'(4'b1101);
            end
            3: begin
                circ_d = CFG_DATA_W'(1); auto_d = '0;
                rt_d = CFG_DATA_W'(RUNTIME_CLAMP_MS); iv_d = CFG_DATA_W'(INTERVAL_CLAMP_MS);
                pref_d = CFG_DATA_W'(PREF_NONE); allow_d = '0; hw_d = '0;
            end
            default: begin
                circ_d  = CFG_DATA_W'($urandom());
                auto_d  = ($urandom_range(0, 4) != 0) ? CFG_DATA_W'(1) : '0;
                pref_d  = CFG_DATA_W'($urandom());
                allow_d = CFG_DATA_W'($urandom());
                hw_d    = $urandom_range(0, 1) ? CFG_DATA_W'(HW_ALL) : CFG_DATA_W'($urandom());
                case ($urandom_range(0, 3))
                    0:       rt_d = CFG_DATA_W'($urandom_range(1, 5000));
                    1:       rt_d = CFG_DATA_W'($urandom_range(5000, 600000));
                    2:       rt_d = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
                    default: rt_d = CFG_DATA_W'($urandom());
                endcase
                case ($urandom_range(0, 3))
                    0:       iv_d = CFG_DATA_W'($urandom_range(0, 2000));
                    1:       iv_d = CFG_DATA_W'($urandom_range(2000, 400000));
                    2:       iv_d = CFG_DATA_W'($urandom());
                    default: iv_d = '0;
                endcase
            end
        endcase
        write_cfg(REG_CIRC_EN, circ_d);
        write_cfg(REG_AUTO_EN, auto_d);
        write_cfg(REG_RUNTIME, rt_d);
        write_cfg(REG_INTERVAL, iv_d);
        write_cfg(REG_PREF_ROUTE, pref_d);
        write_cfg(REG_ALLOW_SUMP, allow_d);
        write_cfg(REG_HW_PRESENT, hw_d);
        // An index past the register file must change nothing
        if (variant == 2)
            write_cfg(REG_UNUSED, CFG_DATA_W'($urandom()));
    endtask

    // One random item. Time mostly moves forward by steps that span the
    // runtime, lockout and settling windows; now and then it jumps or hits zero.
    function automatic tank_req_t random_req();
        tank_req_t   r;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            sim_now = sim_now + $urandom_range(0, 3000);
        else if (sel < 80)
            sim_now = sim_now + $urandom_range(3000, 150000);
        else if (sel < 93)
            sim_now = sim_now + $urandom_range(150000, 1000000);
        else if (sel < 98)
            sim_now = sim_now + $urandom_range(1000000, 100000000);
        else if (sel < 99)
            sim_now = $urandom();
        else
            sim_now = '0;
        r.now_ms          = sim_now;
        r.overflow_sensed = 1'($urandom_range(0, 1));
        r.manual_on       = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        r.level_low  = (sel < 40) || (sel >= 96);
        r.level_high = (sel >= 72);
        sel = $urandom_range(0, 99);
        if (sel < 86)
            r.req_type = REQ_TICK;
        else if (sel < 93)
            r.req_type = REQ_CLEAR;
        else if (sel < 99)
            r.req_type = REQ_MANUAL;
        else
            r.req_type = REQ_RESERVED;
        return r;
    endfunction

    // Hold until every queued item has its result checked, then let the
    // controller settle before touching the registers
    task automatic wait_drained();
        while (rsp_seen_count < req_issued_count)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial begin
        int ph;
        int k;

        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = '0;
        cfg_wdata              = '0;
        req_ch.valid           = 1'b0;
        req_ch.req_type        = REQ_TICK;
        req_ch.now_ms          = '0;
        req_ch.level_low       = 1'b0;
        req_ch.level_high      = 1'b0;
        req_ch.overflow_sensed = 1'b0;
        req_ch.manual_on       = 1'b0;
        rsp_ch.ready           = 1'b0;
        req_issued_count       = 0;
        rsp_seen_count         = 0;
        mismatch_count         = 0;
        sim_now                = 32'd1000;

        // Predictor at its reset values
        cfg_circ_en     = 1'b1;
        cfg_auto_en     = 1'b1;
        cfg_runtime     = RUNTIME_RESET;
        cfg_interval    = INTERVAL_RESET;
        cfg_pref_route  = PREF_AUTO;
        cfg_allow_sump  = 1'b0;
        cfg_hw          = HW_ALL;
        alarm_q         = 1'b0;
        refill_was_on_q = 1'b0;
        manual_q        = 1'b0;
        refill_start_q  = '0;
        last_stop_q     = '0;
        last_dilution_q = '0;
        held_rsp              = '0;
        held_rsp.active_route = ROUTE_NONE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero stamp, auto refill through the fish pump, stop on
        // high level, settling, lockout, sensor conflict alarm, clear, manual
        // refill running into the runtime alarm, reserved code, timestamp wrap
        queue_req(mk_req(REQ_TICK,     32'd0,          1'b0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd1000,       1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd2000,       1'b1, 1'b0, 1'b1, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd3000,       1'b0, 1'b1, 1'b0, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd4000,       1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd200000,     1'b0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd205000,     1'b1, 1'b1, 1'b0, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd206000,     1'b0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_CLEAR,    32'd207000,     1'b1, 1'b1, 1'b1, 1'b1));
        queue_req(mk_req(REQ_MANUAL,   32'd208000,     1'b0, 1'b0, 1'b0, 1'b1));
        queue_req(mk_req(REQ_TICK,     32'd400000,     1'b0, 1'b0, 1'b1, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd999999,     1'b0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd1000000,    1'b0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_CLEAR,    32'd1000001,    1'b0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_MANUAL,   32'd1000002,    1'b0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_RESERVED, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, 1'b1));
        queue_req(mk_req(REQ_TICK,     32'hFFFF_FFF0,  1'b1, 1'b0, 1'b1, 1'b1));
        queue_req(mk_req(REQ_TICK,     32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd0,          1'b1, 1'b0, 1'b1, 1'b0));
        queue_req(mk_req(REQ_TICK,     32'd5,          1'b0, 1'b1, 1'b0, 1'b1));
        queue_req(mk_req(REQ_TICK,     32'h8000_0000,  1'b0, 1'b0, 1'b0, 1'b0));
        wait_drained();

        // Random phases, each under a fresh register setting written while idle
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            program_regs(ph);
            no_gaps = (ph % 4 == 1) || (ph == HOLD_PHASE);
            if (ph == HOLD_PHASE)
                hold_request = 1'b1;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                queue_req(random_req());
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/trpc_pkg.sv
rtl/core/trpc_req_if.sv
rtl/core/trpc_rsp_if.sv
rtl/core/tank_refill_pump_controller.sv
tb/tank_refill_pump_controller_tb.sv
